[design/nmws_pkg.sv]
`default_nettype none

package nmws_pkg;

    localparam int NMWS_WINDOW    = 32;
    localparam int NMWS_MAX_NODES = 32;

    localparam int FILE_W     = 16;
    localparam int CHUNK_W    = 24;
    localparam int ROUND_W    = 16;
    localparam int ASK_W      = 8;
    localparam int NODE_W     = 8;
    localparam int MAP_W      = 32;
    localparam int MAP_IDX_W  = 5;
    localparam int QUIET_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int QUIET_NEEDED = 3;

    localparam logic [FILE_W-1:0]  RST_FILE_ID     = FILE_W'(1);
    localparam logic [CHUNK_W-1:0] RST_CHUNK_TOTAL = '0;
    localparam logic [ROUND_W-1:0] RST_ROUND_LIMIT = ROUND_W'(16);
    localparam logic [ASK_W-1:0]   RST_ASK_LIMIT   = ASK_W'(3);

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_NACK  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_SEND     = 3'd0,
        KIND_STATUS   = 3'd1,
        KIND_COMPLETE = 3'd2,
        KIND_FAILED   = 3'd3,
        KIND_DONE     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_CLOSED = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILE_ID     = 2'd0,
        REG_CHUNK_TOTAL = 2'd1,
        REG_ROUND_LIMIT = 2'd2,
        REG_ASK_LIMIT   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic  capture;
        logic  clr_session;
        logic  merge;
        logic  open_win;
        logic  clr_round;
        logic  idx_clr;
        logic  idx_inc;
        logic  attempt_inc;
        logic  quiet_clr;
        logic  quiet_inc;
        logic  round_inc;
        logic  win_next;
        logic  set_done;
        logic  emit;
        t_kind emit_kind;
        logic  emit_retx;
    } t_cmd;

    typedef struct packed {
        t_action act;
        t_phase  phase;
        logic    base_ge_total;
        logic    bcast_more;
        logic    answered;
        logic    ask_more;
        logic    missing_nz;
        logic    quiet_full;
        logic    round_last;
        logic    scan_end;
        logic    scan_hit;
        logic    chunk_past;
        logic    out_free;
    } t_status;

endpackage

`default_nettype wire

[design/nmws_in_if.sv]
`default_nettype none

interface nmws_in_if import nmws_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic [FILE_W-1:0]   nack_file;
    logic [CHUNK_W-1:0]  nack_window;
    logic [NODE_W-1:0]   nack_node;
    logic [MAP_W-1:0]    nack_missing;

    modport source (
        output valid, action, nack_file, nack_window, nack_node, nack_missing,
        input  ready
    );
    modport sink (
        input  valid, action, nack_file, nack_window, nack_node, nack_missing,
        output ready
    );
endinterface

`default_nettype wire

[design/nmws_out_if.sv]
`default_nettype none

interface nmws_out_if import nmws_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic [CHUNK_W-1:0]  chunk_number;
    logic [CHUNK_W-1:0]  window_number;
    logic [ROUND_W-1:0]  round_number;
    logic                is_retransmit;
    logic                last;

    modport source (
        output valid, kind, chunk_number, window_number, round_number, is_retransmit,
               last,
        input  ready
    );
    modport sink (
        input  valid, kind, chunk_number, window_number, round_number, is_retransmit,
               last,
        output ready
    );
endinterface

`default_nettype wire

[design/nmws_ctrl.sv]
`default_nettype none

module nmws_ctrl import nmws_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IN,
        S_DECODE,
        S_ADVANCE,
        S_BCAST,
        S_ROUND,
        S_TICK,
        S_SCAN,
        S_RLIM
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IN);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_kind = KIND_SEND;
        case (r_state)
            S_IN: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.act)
                    ACT_START: begin
                        o_cmd.clr_session = 1'b1;
                        n_state           = S_ADVANCE;
                    end
                    ACT_NACK: begin
                        o_cmd.merge = 1'b1;
                        n_state     = S_IN;
                    end
                    ACT_TICK: begin
                        if (i_status.phase == PH_WAIT) begin
                            n_state = S_TICK;
                        end else if (i_status.phase == PH_CLOSED) begin
                            n_state = S_ADVANCE;
                        end else begin
                            n_state = S_IN;
                        end
                    end
                    default: n_state = S_IN;
                endcase
            end
            S_ADVANCE: begin
                if (i_status.base_ge_total) begin
                    if (i_status.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = KIND_DONE;
                        o_cmd.set_done  = 1'b1;
                        n_state         = S_IN;
                    end
                end else begin
                    o_cmd.open_win = 1'b1;
                    n_state        = S_BCAST;
                end
            end
            S_BCAST: begin
                if (i_status.bcast_more) begin
                    if (i_status.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = KIND_SEND;
                        o_cmd.idx_inc   = 1'b1;
                    end
                end else begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (i_status.out_free) begin
                    o_cmd.clr_round = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_STATUS;
                    n_state         = S_IN;
                end
            end
            S_TICK: begin
                if (!i_status.answered && i_status.ask_more) begin
                    if (i_status.out_free) begin
                        o_cmd.attempt_inc = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_kind   = KIND_STATUS;
                        n_state           = S_IN;
                    end
                end else if (i_status.missing_nz) begin
                    o_cmd.idx_clr   = 1'b1;
                    o_cmd.quiet_clr = 1'b1;
                    n_state         = S_SCAN;
                end else if (i_status.answered) begin
                    if (i_status.quiet_full) begin
                        if (i_status.out_free) begin
                            o_cmd.quiet_clr = 1'b1;
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = KIND_COMPLETE;
                            o_cmd.win_next  = 1'b1;
                            n_state         = S_IN;
                        end
                    end else begin
                        o_cmd.quiet_inc = 1'b1;
                        n_state         = S_RLIM;
                    end
                end else begin
                    o_cmd.quiet_clr = 1'b1;
                    n_state         = S_RLIM;
                end
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_RLIM;
                end else if (!i_status.scan_hit) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (i_status.chunk_past) begin
                    n_state = S_RLIM;
                end else if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = KIND_SEND;
                    o_cmd.emit_retx = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                end
            end
            S_RLIM: begin
                if (i_status.round_last) begin
                    if (i_status.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = KIND_FAILED;
                        o_cmd.win_next  = 1'b1;
                        n_state         = S_IN;
                    end
                end else begin
                    o_cmd.round_inc = 1'b1;
                    n_state         = S_ROUND;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[design/nmws_dp.sv]
`default_nettype none

module nmws_dp import nmws_pkg::*; #(
    parameter int WINDOW    = NMWS_WINDOW,
    parameter int MAX_NODES = NMWS_MAX_NODES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    nmws_in_if.sink                    i_in,
    nmws_out_if.source                 o_out
);

    localparam int IDX_RAW = $clog2(WINDOW + 1);
    localparam int IDX_W   = (IDX_RAW > MAP_IDX_W) ? IDX_RAW : MAP_IDX_W;
    localparam int SCAN_N  = (WINDOW < MAP_W) ? WINDOW : MAP_W;
    localparam int BASE_W  = CHUNK_W + IDX_RAW;
    localparam logic [MAP_W-1:0] WMASK =
        (WINDOW >= MAP_W) ? '1 : MAP_W'((64'(1) << WINDOW) - 64'(1));

    logic [FILE_W-1:0]  r_file_id;
    logic [CHUNK_W-1:0] r_chunk_total;
    logic [ROUND_W-1:0] r_round_limit;
    logic [ASK_W-1:0]   r_ask_limit;

    t_action            r_act;
    logic [FILE_W-1:0]  r_nfile;
    logic [CHUNK_W-1:0] r_nwin;
    logic [BASE_W-1:0]  r_nbase;
    logic [NODE_W-1:0]  r_nnode;
    logic [MAP_W-1:0]   r_nmiss;

    t_phase             r_phase;
    logic [CHUNK_W-1:0] r_cur_win;
    logic [BASE_W-1:0]  r_base;
    logic [ROUND_W-1:0] r_round;
    logic [ASK_W-1:0]   r_attempt;
    logic [QUIET_W-1:0] r_quiet;
    logic [MAP_W-1:0]   r_missing;
    logic [MAP_W-1:0]   r_resp;
    logic [MAP_W-1:0]   r_known;
    logic [IDX_W-1:0]   r_idx;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [CHUNK_W-1:0] r_out_chunk;
    logic [CHUNK_W-1:0] r_out_window;
    logic [ROUND_W-1:0] r_out_round;
    logic               r_out_retx;

    logic [BASE_W:0]    w_sum;
    logic [BASE_W:0]    w_total;
    logic [ASK_W-1:0]   w_alimit;
    logic [ROUND_W-1:0] w_rlimit;
    logic               w_nack_ok;
    logic               w_nack_cur;
    logic               w_node_ok;
    logic [MAP_W-1:0]   w_node_bit;

    always_comb begin
        w_sum      = (BASE_W + 1)'(r_base) + (BASE_W + 1)'(r_idx);
        w_total    = (BASE_W + 1)'(r_chunk_total);
        w_alimit   = (r_ask_limit == '0) ? ASK_W'(1) : r_ask_limit;
        w_rlimit   = (r_round_limit == '0) ? ROUND_W'(1) : r_round_limit;
        w_nack_ok  = (r_nfile == r_file_id) && (r_nbase < BASE_W'(r_chunk_total));
        w_nack_cur = (r_phase == PH_WAIT) && (r_nwin == r_cur_win);
        w_node_ok  = r_nnode < NODE_W'(MAX_NODES);
        w_node_bit = MAP_W'(1) << r_nnode[MAP_IDX_W-1:0];

        o_status.act           = r_act;
        o_status.phase         = r_phase;
        o_status.base_ge_total = r_base >= BASE_W'(r_chunk_total);
        o_status.bcast_more    = (r_idx < IDX_W'(WINDOW)) && (w_sum < w_total);
        o_status.answered      = (r_known == '0) || ((r_resp & r_known) == r_known);
        o_status.ask_more      = ((ASK_W + 1)'(r_attempt) + (ASK_W + 1)'(1))
                                 < (ASK_W + 1)'(w_alimit);
        o_status.missing_nz    = r_missing != '0;
        o_status.quiet_full    = r_quiet >= QUIET_W'(QUIET_NEEDED - 1);
        o_status.round_last    = ((ROUND_W + 1)'(r_round) + (ROUND_W + 1)'(1))
                                 >= (ROUND_W + 1)'(w_rlimit);
        o_status.scan_end      = r_idx >= IDX_W'(SCAN_N);
        o_status.scan_hit      = r_missing[r_idx[MAP_IDX_W-1:0]];
        o_status.chunk_past    = w_sum >= w_total;
        o_status.out_free      = !r_out_valid || o_out.ready;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out_kind;
    assign o_out.chunk_number  = r_out_chunk;
    assign o_out.window_number = r_out_window;
    assign o_out.round_number  = r_out_round;
    assign o_out.is_retransmit = r_out_retx;
    assign o_out.last          = (r_out_kind != KIND_SEND);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act   <= t_action'(i_in.action);
            r_nfile <= i_in.nack_file;
            r_nwin  <= i_in.nack_window;
            r_nbase <= BASE_W'(i_in.nack_window) * BASE_W'(WINDOW);
            r_nnode <= i_in.nack_node;
            r_nmiss <= i_in.nack_missing;
        end
        if (i_cmd.emit) begin
            r_out_kind   <= i_cmd.emit_kind;
            r_out_chunk  <= (i_cmd.emit_kind == KIND_SEND) ? w_sum[CHUNK_W-1:0] : '0;
            r_out_window <= r_cur_win;
            r_out_round  <= r_round;
            r_out_retx   <= i_cmd.emit_retx;
        end
        if (i_cmd.open_win || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_id     <= RST_FILE_ID;
            r_chunk_total <= RST_CHUNK_TOTAL;
            r_round_limit <= RST_ROUND_LIMIT;
            r_ask_limit   <= RST_ASK_LIMIT;
            r_phase       <= PH_IDLE;
            r_cur_win     <= '0;
            r_base        <= '0;
            r_round       <= '0;
            r_attempt     <= '0;
            r_quiet       <= '0;
            r_missing     <= '0;
            r_resp        <= '0;
            r_known       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_FILE_ID:     r_file_id     <= i_cfg_wdata[FILE_W-1:0];
                    REG_CHUNK_TOTAL: r_chunk_total <= i_cfg_wdata[CHUNK_W-1:0];
                    REG_ROUND_LIMIT: r_round_limit <= i_cfg_wdata[ROUND_W-1:0];
                    REG_ASK_LIMIT:   r_ask_limit   <= i_cfg_wdata[ASK_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.clr_session) begin
                r_cur_win <= '0;
                r_base    <= '0;
                r_round   <= '0;
                r_attempt <= '0;
                r_quiet   <= '0;
                r_missing <= '0;
                r_resp    <= '0;
                r_known   <= '0;
            end

            if (i_cmd.merge && w_nack_ok) begin
                if (w_nack_cur) begin
                    r_missing <= r_missing | (r_nmiss & WMASK);
                end
                if (w_node_ok) begin
                    r_known <= r_known | w_node_bit;
                    if (w_nack_cur) begin
                        r_resp <= r_resp | w_node_bit;
                    end
                end
            end

            if (i_cmd.open_win) begin
                r_round <= '0;
                r_quiet <= '0;
            end

            if (i_cmd.clr_round) begin
                r_missing <= '0;
                r_resp    <= '0;
                r_attempt <= '0;
                r_phase   <= PH_WAIT;
            end

            if (i_cmd.attempt_inc) begin
                r_attempt <= r_attempt + ASK_W'(1);
            end

            if (i_cmd.quiet_clr) begin
                r_quiet <= '0;
            end else if (i_cmd.quiet_inc) begin
                r_quiet <= r_quiet + QUIET_W'(1);
            end

            if (i_cmd.round_inc) begin
                r_round <= r_round + ROUND_W'(1);
            end

            if (i_cmd.win_next) begin
                r_cur_win <= r_cur_win + CHUNK_W'(1);
                r_base    <= r_base + BASE_W'(WINDOW);
                r_phase   <= PH_CLOSED;
            end

            if (i_cmd.set_done) begin
                r_phase <= PH_DONE;
            end
        end
    end

endmodule

`default_nettype wire

[design/nack_multicast_window_sender.sv]
`default_nettype none

// Sender controller for windowed reliable multicast.
// Input channel i_in carries events: start, a received NACK, or a tick that ends a
// status wait. Output channel o_out carries commands and reports: chunk sends,
// status requests, window complete, window failed, session done; last marks the
// final result of one event. Configuration registers (file id, chunk total,
// round limit, ask limit) are written through i_cfg_wr_en / i_cfg_index /
// i_cfg_wdata, by the user only between events; the block does not enforce this.
// Timing: an event is captured from i_in and decoded in the next cycle; a NACK
// produces no result. Results leave one per cycle at most, and only while the
// receiver takes them. A broadcast sends the window's chunks one after another and
// then a status request; a retransmit pass scans the missing bitmap bit by bit, up
// to 32 bits, sends a retransmit for each set bit, and then does round bookkeeping:
// a status request for the next round or a window-failed report.
// Reset clears the phase, window, round and bitmap state and the output valid, and
// loads the register defaults; the block then waits for a start event.
// A stalled receiver holds the output register; the sequencer then waits and takes
// no new event until the current event's last result has entered that register.
module nack_multicast_window_sender import nmws_pkg::*; #(
    parameter int WINDOW    = NMWS_WINDOW,
    parameter int MAX_NODES = NMWS_MAX_NODES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    nmws_in_if.sink                    i_in,
    nmws_out_if.source                 o_out
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    nmws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    nmws_dp #(
        .WINDOW    (WINDOW),
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in        (i_in),
        .o_out       (o_out)
    );

    a_decode_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("event taken while previous event still decoding");

    a_retx_is_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_retransmit |-> o_out.kind == KIND_SEND)
        else $error("retransmit flag on a non-send result");

    a_chunk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.kind != KIND_SEND) |-> o_out.chunk_number == '0)
        else $error("chunk number set on a report");

    a_nack_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && (i_in.action == ACT_NACK) |=> ##1
            (!o_out.valid || $past(o_out.valid && !o_out.ready)))
        else $error("NACK caused a result");

endmodule

`default_nettype wire
